@@ sv/sliding_piece_attack_set_defines.svh @@
// ----------------------------------------------------------------------------
// Sliding piece attack set - assertion macros
// Shared concurrent check forms for the attack set pipeline.
// ----------------------------------------------------------------------------
`ifndef SLIDING_PIECE_ATTACK_SET_DEFINES_SVH
`define SLIDING_PIECE_ATTACK_SET_DEFINES_SVH

// same-cycle implication
`define SPA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spa: same-cycle check failed");

// next-cycle implication
`define SPA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spa: next-cycle check failed");

`endif

@@ sv/spa_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding piece attack set - package
// Board types, ray direction codes and ray geometry functions.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int unsigned BOARD_BITS = 64;
    localparam int unsigned RAYS       = 4;
    localparam int unsigned SQ_W       = 6;
    localparam int unsigned COORD_W    = 3;
    localparam int unsigned S_DATA_W   = 72;
    localparam int unsigned M_DATA_W   = 128;

    localparam logic KIND_ROOK   = 1'b0;
    localparam logic KIND_BISHOP = 1'b1;

    // forward rays run toward higher square numbers, back rays toward lower
    localparam logic [1:0] DIR_FWD_A  = 2'd0;
    localparam logic [1:0] DIR_FWD_B  = 2'd1;
    localparam logic [1:0] DIR_BACK_A = 2'd2;
    localparam logic [1:0] DIR_BACK_B = 2'd3;

    typedef logic [BOARD_BITS-1:0]           board_t;
    typedef logic [RAYS-1:0][BOARD_BITS-1:0] ray_set_t;
    typedef logic [SQ_W-1:0]                 square_t;

    function automatic board_t ray_mask(input logic kind, input square_t sq,
                                        input logic [1:0] dir);
        board_t               m;
        logic [COORD_W-1:0]   rank;
        logic [COORD_W-1:0]   file;
        logic [COORD_W-1:0]   tr;
        logic [COORD_W-1:0]   tf;
        logic signed [COORD_W:0] dr;
        logic signed [COORD_W:0] df;
        logic                 hit;
        rank = sq[SQ_W-1:COORD_W];
        file = sq[COORD_W-1:0];
        m    = '0;
        for (int t = 0; t < BOARD_BITS; t++) begin
            tr = COORD_W'(t >> COORD_W);
            tf = COORD_W'(t);
            dr = $signed({1'b0, tr}) - $signed({1'b0, rank});
            df = $signed({1'b0, tf}) - $signed({1'b0, file});
            unique case ({kind, dir})
                {KIND_ROOK, DIR_FWD_A}:    hit = (df == 0) && (dr > 0);
                {KIND_ROOK, DIR_FWD_B}:    hit = (dr == 0) && (df > 0);
                {KIND_ROOK, DIR_BACK_A}:   hit = (df == 0) && (dr < 0);
                {KIND_ROOK, DIR_BACK_B}:   hit = (dr == 0) && (df < 0);
                {KIND_BISHOP, DIR_FWD_A}:  hit = (dr == df) && (dr > 0);
                {KIND_BISHOP, DIR_FWD_B}:  hit = (dr == -df) && (dr > 0);
                {KIND_BISHOP, DIR_BACK_A}: hit = (dr == -df) && (dr < 0);
                {KIND_BISHOP, DIR_BACK_B}: hit = (dr == df) && (dr < 0);
                default:                   hit = 1'b0;
            endcase
            m[t] = hit;
        end
        return m;
    endfunction

    // squares kept in the relevant mask: drop the edge the ray runs into
    function automatic board_t edge_keep(input logic kind, input logic [1:0] dir);
        board_t             m;
        logic [COORD_W-1:0] tr;
        logic [COORD_W-1:0] tf;
        logic               rank_in;
        logic               file_in;
        m = '0;
        for (int t = 0; t < BOARD_BITS; t++) begin
            tr      = COORD_W'(t >> COORD_W);
            tf      = COORD_W'(t);
            rank_in = (tr != '0) && (tr != '1);
            file_in = (tf != '0) && (tf != '1);
            if (kind == KIND_BISHOP) begin
                m[t] = rank_in && file_in;
            end else if (dir == DIR_FWD_A || dir == DIR_BACK_A) begin
                m[t] = rank_in;
            end else begin
                m[t] = file_in;
            end
        end
        return m;
    endfunction

    function automatic board_t rev_board(input board_t b);
        board_t r;
        for (int i = 0; i < BOARD_BITS; i++) begin
            r[i] = b[BOARD_BITS-1-i];
        end
        return r;
    endfunction

endpackage

@@ sv/spa_ray_gen.sv @@
// ----------------------------------------------------------------------------
// Sliding piece attack set - ray decode stage
// Expands the origin square into four ray masks and the relevant mask.
// ----------------------------------------------------------------------------
module spa_ray_gen (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic              kind,
    input  spa_pkg::square_t  square,
    input  spa_pkg::board_t   occupancy,
    output logic              valid_reg,
    output spa_pkg::ray_set_t ray_reg,
    output spa_pkg::board_t   occ_reg,
    output spa_pkg::board_t   rel_reg
);

    spa_pkg::ray_set_t ray_next;
    spa_pkg::board_t   rel_next;

    always_comb begin
        rel_next = '0;
        for (int d = 0; d < spa_pkg::RAYS; d++) begin
            ray_next[d] = spa_pkg::ray_mask(kind, square, 2'(d));
            rel_next    = rel_next | (ray_next[d] & spa_pkg::edge_keep(kind, 2'(d)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            ray_reg <= ray_next;
            occ_reg <= occupancy;
            rel_reg <= rel_next;
        end
    end

endmodule

@@ sv/spa_ray_fill.sv @@
// ----------------------------------------------------------------------------
// Sliding piece attack set - blocker fill stage
// Finds the first blocker on each ray and builds the reach mask up to it.
// ----------------------------------------------------------------------------
module spa_ray_fill (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  spa_pkg::ray_set_t ray,
    input  spa_pkg::board_t   occ,
    input  spa_pkg::board_t   rel,
    output logic              valid_reg,
    output spa_pkg::ray_set_t ray_reg,
    output spa_pkg::ray_set_t fill_reg,
    output spa_pkg::board_t   rel_reg
);

    spa_pkg::ray_set_t blk;
    spa_pkg::ray_set_t low;
    spa_pkg::ray_set_t fill_next;

    // bits up to and including the lowest blocker (highest for back rays, via bit reversal); all ones with no blocker
    always_comb begin
        for (int d = 0; d < spa_pkg::RAYS; d++) begin
            if (d >= spa_pkg::RAYS / 2) begin
                blk[d] = spa_pkg::rev_board(ray[d] & occ);
            end else begin
                blk[d] = ray[d] & occ;
            end
            low[d] = blk[d] ^ (blk[d] - spa_pkg::board_t'(1));
            if (d >= spa_pkg::RAYS / 2) begin
                fill_next[d] = spa_pkg::rev_board(low[d]);
            end else begin
                fill_next[d] = low[d];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            ray_reg  <= ray;
            fill_reg <= fill_next;
            rel_reg  <= rel;
        end
    end

endmodule

@@ sv/sliding_piece_attack_set.sv @@
// ----------------------------------------------------------------------------
// Sliding piece attack set - top level
// Rook or bishop ray attacks and relevant occupancy mask, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one beat per query. s_tuser holds the piece kind
//   (0 rook, 1 bishop); s_tdata holds the origin square and the occupancy.
//   Output stream m_*: one beat per query, in order, carrying the attack set
//   (first blocker on each ray included) and the relevant occupancy mask.
//   Pipeline: an accepted input beat passes the registered stages ray decode,
//   blocker fill and ray merge before it shows on m_tvalid.
//   Throughput: one beat per cycle while m_tready stays high.
//   Stall: with m_tready low the output beat holds; bubbles in the earlier
//   stages still fill, then s_tready drops once every stage holds a beat.
//   Reset: aresetn low clears all stage valid bits; no beat is in flight
//   afterward and s_tready is high on the first cycle out of reset.
// ----------------------------------------------------------------------------
`include "sliding_piece_attack_set_defines.svh"

module sliding_piece_attack_set (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [5:0] square, [69:6] occupancy, [71:70] zero
    input  logic [spa_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] func
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [63:0] attacks, [127:64] relevant_mask
    output logic [spa_pkg::M_DATA_W-1:0]   m_tdata
);

    logic              en_gen;
    logic              en_fill;
    logic              en_out;
    logic              gen_valid;
    spa_pkg::ray_set_t gen_ray;
    spa_pkg::board_t   gen_occ;
    spa_pkg::board_t   gen_rel;
    logic              fill_valid;
    spa_pkg::ray_set_t fill_ray;
    spa_pkg::ray_set_t fill_mask;
    spa_pkg::board_t   fill_rel;
    spa_pkg::board_t   att_next;
    logic              out_valid_reg;
    spa_pkg::board_t   att_reg;
    spa_pkg::board_t   rel_reg;

    assign en_out   = !out_valid_reg || m_tready;
    assign en_fill  = !fill_valid || en_out;
    assign en_gen   = !gen_valid || en_fill;
    assign s_tready = en_gen;

    spa_ray_gen u_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en_gen),
        .in_valid  (s_tvalid),
        .kind      (s_tuser),
        .square    (s_tdata[spa_pkg::SQ_W-1:0]),
        .occupancy (s_tdata[spa_pkg::SQ_W +: spa_pkg::BOARD_BITS]),
        .valid_reg (gen_valid),
        .ray_reg   (gen_ray),
        .occ_reg   (gen_occ),
        .rel_reg   (gen_rel)
    );

    spa_ray_fill u_fill (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en_fill),
        .in_valid  (gen_valid),
        .ray       (gen_ray),
        .occ       (gen_occ),
        .rel       (gen_rel),
        .valid_reg (fill_valid),
        .ray_reg   (fill_ray),
        .fill_reg  (fill_mask),
        .rel_reg   (fill_rel)
    );

    always_comb begin
        att_next = '0;
        for (int d = 0; d < spa_pkg::RAYS; d++) begin
            att_next = att_next | (fill_ray[d] & fill_mask[d]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en_out) begin
            out_valid_reg <= fill_valid;
        end
        if (en_out) begin
            att_reg <= att_next;
            rel_reg <= fill_rel;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {rel_reg, att_reg};

    `SPA_ASSERT_IMP(a_ready_when_out_empty, aclk, aresetn, !m_tvalid, s_tready)
    `SPA_ASSERT_NXT(a_fill_moves_up, aclk, aresetn, fill_valid && m_tready, m_tvalid)
    `SPA_ASSERT_IMP(a_att_count, aclk, aresetn, m_tvalid, $countones(att_reg) <= 14)
    `SPA_ASSERT_IMP(a_rel_count, aclk, aresetn, m_tvalid, $countones(rel_reg) <= 12)

endmodule

@@ verif/sliding_piece_attack_set_tb.sv @@
// ----------------------------------------------------------------------------
// Sliding piece attack set - testbench
// Drives rook and bishop queries over the input stream and checks the attack set
// and relevant occupancy mask of every output beat against typed values or a
// ray-walking predictor, with random stalls on both streams, long on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_piece_attack_set_tb;

    localparam int HOLD_CYCLES = 64;
    localparam int IDLE_LIMIT  = 1000;
    localparam int N_DIRECTED  = 22;

    typedef struct packed {
        spa_pkg::board_t relevant;
        spa_pkg::board_t attacks;
    } attack_result_t;

    typedef struct packed {
        logic             kind;
        spa_pkg::square_t sq;
        spa_pkg::board_t  occ;
        logic             typed;
        spa_pkg::board_t  exp_att;
        spa_pkg::board_t  exp_rel;
    } query_row_t;

    localparam query_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{spa_pkg::KIND_ROOK,   6'd0,  64'h0,                 1'b1,
          64'h01010101010101FE, 64'h000101010101017E},
        '{spa_pkg::KIND_ROOK,   6'd0,  64'h0000000000000001,  1'b1,
          64'h01010101010101FE, 64'h000101010101017E},
        '{spa_pkg::KIND_ROOK,   6'd0,  64'hFFFFFFFFFFFFFFFF,  1'b1,
          64'h0000000000000102, 64'h000101010101017E},
        '{spa_pkg::KIND_BISHOP, 6'd0,  64'h0,                 1'b1,
          64'h8040201008040200, 64'h0040201008040200},
        '{spa_pkg::KIND_BISHOP, 6'd0,  64'hFFFFFFFFFFFFFFFF,  1'b1,
          64'h0000000000000200, 64'h0040201008040200},
        '{spa_pkg::KIND_ROOK,   6'd63, 64'hFFFFFFFFFFFFFFFF,  1'b1,
          64'h4080000000000000, 64'h7E80808080808000},
        '{spa_pkg::KIND_BISHOP, 6'd63, 64'hFFFFFFFFFFFFFFFF,  1'b1,
          64'h0040000000000000, 64'h0040201008040200},
        '{spa_pkg::KIND_ROOK,   6'd63, 64'h0,                 1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_BISHOP, 6'd63, 64'h0,                 1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_ROOK,   6'd7,  64'h0,                 1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_BISHOP, 6'd7,  64'h0,                 1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_ROOK,   6'd56, 64'hFFFFFFFFFFFFFFFF,  1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_BISHOP, 6'd56, 64'h0,                 1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_ROOK,   6'd27, 64'h0,                 1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_BISHOP, 6'd27, 64'hFFFFFFFFFFFFFFFF,  1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_ROOK,   6'd36, 64'h5555555555555555,  1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_BISHOP, 6'd36, 64'hAAAAAAAAAAAAAAAA,  1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_ROOK,   6'd28, 64'h0000000010000000,  1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_BISHOP, 6'd9,  64'hFFFFFFFFFFFFFDFF,  1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_ROOK,   6'd35, 64'h8000000000000001,  1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_BISHOP, 6'd42, 64'h0F0F0F0F0F0F0F0F,  1'b0, 64'h0, 64'h0},
        '{spa_pkg::KIND_ROOK,   6'd12, 64'h00FF00FF00FF00FF,  1'b0, 64'h0, 64'h0}
    };

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [spa_pkg::S_DATA_W-1:0]     s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [spa_pkg::M_DATA_W-1:0]     m_tdata;

    attack_result_t expected_attack_sets [$];
    attack_result_t got_set;
    attack_result_t want_set;

    int  tx_stall_pct;
    int  rx_stall_pct;
    bit  hold_output;
    int  queries_sent;
    int  bishop_queries;
    int  beats_checked;
    int  mismatches;
    int  idle_cycles;

    sliding_piece_attack_set dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic attack_result_t ray_attack_set(input logic kind,
                                                      input spa_pkg::square_t sq,
                                                      input spa_pkg::board_t occ);
        int             rook_dr [4]   = '{1, -1, 0, 0};
        int             rook_df [4]   = '{0, 0, 1, -1};
        int             bishop_dr [4] = '{1, 1, -1, -1};
        int             bishop_df [4] = '{1, -1, 1, -1};
        int             dr;
        int             df;
        int             r;
        int             f;
        bit             blocked;
        attack_result_t res;
        res = '0;
        for (int d = 0; d < 4; d++) begin
            dr      = (kind == spa_pkg::KIND_BISHOP) ? bishop_dr[d] : rook_dr[d];
            df      = (kind == spa_pkg::KIND_BISHOP) ? bishop_df[d] : rook_df[d];
            r       = int'(sq[5:3]) + dr;
            f       = int'(sq[2:0]) + df;
            blocked = 1'b0;
            while (r >= 0 && r <= 7 && f >= 0 && f <= 7) begin
                if (!blocked) begin
                    res.attacks[r*8+f] = 1'b1;
                    if (occ[r*8+f]) blocked = 1'b1;
                end
                if ((dr == 0 || (r >= 1 && r <= 6)) && (df == 0 || (f >= 1 && f <= 6)))
                    res.relevant[r*8+f] = 1'b1;
                r += dr;
                f += df;
            end
        end
        return res;
    endfunction

    function automatic spa_pkg::board_t random_occupancy();
        spa_pkg::board_t a;
        spa_pkg::board_t b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: return a;
            1: return a & b;
            2: return a & b & {$urandom, $urandom};
            3: return a | b;
            4: return '0;
            5: return '1;
            default: return spa_pkg::board_t'(1) << $urandom_range(0, 63);
        endcase
    endfunction

    task automatic offer_query(input logic kind, input spa_pkg::square_t sq,
                               input spa_pkg::board_t occ,
                               input logic typed, input attack_result_t typed_set);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, occ, sq};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_attack_sets.push_back(typed ? typed_set : ray_attack_set(kind, sq, occ));
        queries_sent++;
        if (kind == spa_pkg::KIND_BISHOP) bishop_queries++;
        if ($urandom_range(0, 99) < tx_stall_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic offer_random(input int count);
        logic             kind;
        spa_pkg::square_t sq;
        spa_pkg::board_t  occ;
        for (int n = 0; n < count; n++) begin
            kind = logic'($urandom_range(0, 1));
            sq   = spa_pkg::square_t'($urandom_range(0, 63));
            occ  = random_occupancy();
            if ($urandom_range(0, 3) == 0) occ[sq] = 1'b1;
            offer_query(kind, sq, occ, 1'b0, '0);
        end
    endtask

    task automatic note_mismatch(input string what, input spa_pkg::board_t want,
                                 input spa_pkg::board_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %h got %h", $realtime, what, want, got);
    endtask

    // hold off output for a long stretch on request, else stall in random bursts
    initial begin
        m_tready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_set = m_tdata;
            beats_checked++;
            if (expected_attack_sets.size() == 0) begin
                note_mismatch("unexpected beat", '0, got_set.attacks);
            end else begin
                want_set = expected_attack_sets.pop_front();
                if (got_set.attacks !== want_set.attacks)
                    note_mismatch("attacks", want_set.attacks, got_set.attacks);
                if (got_set.relevant !== want_set.relevant)
                    note_mismatch("relevant_mask", want_set.relevant, got_set.relevant);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("sliding_piece_attack_set_tb: FAIL");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        tx_stall_pct   = 4;
        rx_stall_pct   = 4;
        hold_output    = 1'b0;
        queries_sent   = 0;
        bishop_queries = 0;
        beats_checked  = 0;
        mismatches     = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            offer_query(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].sq, DIRECTED_ROWS[i].occ,
                        DIRECTED_ROWS[i].typed,
                        {DIRECTED_ROWS[i].exp_rel, DIRECTED_ROWS[i].exp_att});
        end

        offer_random(200);

        // fill the pipeline against a held output
        tx_stall_pct = 0;
        hold_output  = 1'b1;
        offer_random(40);

        // drain completely before resuming
        s_tvalid <= 1'b0;
        while (expected_attack_sets.size() != 0) @(posedge aclk);

        tx_stall_pct = 12;
        rx_stall_pct = 12;
        offer_random(200);

        tx_stall_pct = 0;
        rx_stall_pct = 0;
        offer_random(160);

        s_tvalid <= 1'b0;
        while (expected_attack_sets.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d queries (%0d rook, %0d bishop), %0d result beats checked",
                 queries_sent, queries_sent - bishop_queries, bishop_queries, beats_checked);
        $display("included a %0d-cycle output hold-off, a full drain pause and %0d mismatches",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0 && expected_attack_sets.size() == 0) begin
            $display("sliding_piece_attack_set_tb: PASS");
        end else begin
            $display("sliding_piece_attack_set_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sliding_piece_attack_set.f @@
+incdir+sv
sv/spa_pkg.sv
sv/spa_ray_gen.sv
sv/spa_ray_fill.sv
sv/sliding_piece_attack_set.sv
verif/sliding_piece_attack_set_tb.sv
